>>> rtl/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion macros. They compile away when SYNTH is defined.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// A property that must hold at every clock edge outside reset.
`define MTS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// A condition that must never be true outside reset.
`define MTS_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define MTS_ASSERT(lbl, clk, rstn, prop, msg)
`define MTS_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

>>> rtl/mts_pkg.sv
// ============================================================================
// Min-tracking stack package
// Shared constants, codes and controller/datapath interface types.
// ============================================================================
`default_nettype none

package mts_pkg;

    localparam int STACK_DEPTH_DEFAULT = 64;
    localparam int VAL_W  = 16;
    localparam int WORD_W = 18;

    // Operation codes; the fourth code acts as a query.
    localparam logic [1:0] FUNC_PUSH  = 2'd0;
    localparam logic [1:0] FUNC_POP   = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       push_en;
        logic       pop_en;
        logic       finish;
        logic [1:0] status;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] func;
        logic       empty;
        logic       full;
    } sts_t;

endpackage

`default_nettype wire

>>> rtl/min_tracking_stack_top.sv
// ============================================================================
// Min-tracking stack
// Bounded stack of signed 16-bit values that reports its current minimum.
// ============================================================================
// Usage:
//   An operation transfer is taken at a rising edge where start is high and
//   busy is low; func selects push, pop or query and push_value carries the
//   value for a push. The unused fourth func code behaves as a query.
//   Exactly one result follows each operation: done is high for one cycle
//   and popped_value, current_minimum, status and is_empty are valid in that
//   cycle only. The receiver must take the result then; it cannot stall.
//   The accepting edge latches the operation and launches the read of the
//   top entry from the registered-read memory, and the following cycle,
//   with busy high, decodes it and updates the count and minimum; the
//   result registers and done are loaded at the edge that ends that cycle.
//   No operation is accepted while busy is high, but a new operation may be
//   accepted in the same cycle that the previous result is presented on done.
//   Reset empties the stack and clears the minimum; memory contents are not
//   cleared, since only entries below the count are ever used.
//   A push onto a full stack reports status full and changes nothing, and a
//   pop from an empty stack reports status empty with popped_value zero.
// ============================================================================
`default_nettype none

`include "assert_macros.svh"

module min_tracking_stack_top #(
    parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        func,
    input  logic signed [mts_pkg::VAL_W-1:0]  push_value,
    output logic                              done,
    output logic signed [mts_pkg::VAL_W-1:0]  popped_value,
    output logic signed [mts_pkg::VAL_W-1:0]  current_minimum,
    output logic [1:0]                        status,
    output logic                              is_empty
);

    import mts_pkg::*;

    // Commands and status between the sequencer and the datapath.
    cmd_t cmd;
    sts_t sts;

    mts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    mts_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .func            (func),
        .push_value      (push_value),
        .done            (done),
        .popped_value    (popped_value),
        .current_minimum (current_minimum),
        .status          (status),
        .is_empty        (is_empty)
    );

    // Every accepted transfer yields a result on done.
    `MTS_ASSERT(a_result_latency, clk, rst_n, (start && !busy) |-> ##2 done, "result missing")
    // A result is never shown while an operation is still executing.
    `MTS_NEVER(a_done_not_busy, clk, rst_n, done && busy, "result during execution")
    // An empty-stack pop leaves the stack empty and returns zero.
    `MTS_ASSERT(a_empty_pop, clk, rst_n,
        (done && status == STAT_EMPTY) |-> (is_empty && popped_value == '0), "bad empty pop")
    // An empty stack reports a zero minimum.
    `MTS_ASSERT(a_empty_min, clk, rst_n,
        (done && is_empty) |-> (current_minimum == '0), "nonzero minimum when empty")

endmodule

`default_nettype wire

>>> rtl/mts_ram.sv
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ============================================================================
`default_nettype none

module mts_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/mts_ctrl.sv
// ============================================================================
// Min-tracking stack controller
// Two-state sequencer that decodes the latched operation into datapath commands.
// ============================================================================
`default_nettype none

module mts_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  mts_pkg::sts_t sts,
    output mts_pkg::cmd_t cmd
);

    import mts_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.status  = STAT_OK;
        busy        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                busy       = 1'b1;
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
                if (sts.func == FUNC_PUSH)
                begin
                    if (sts.full)
                    begin
                        cmd.status = STAT_FULL;
                    end
                    else
                    begin
                        cmd.push_en = 1'b1;
                    end
                end
                else if (sts.func == FUNC_POP)
                begin
                    if (sts.empty)
                    begin
                        cmd.status = STAT_EMPTY;
                    end
                    else
                    begin
                        cmd.pop_en = 1'b1;
                    end
                end
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/mts_dp.sv
// ============================================================================
// Min-tracking stack datapath
// Entry memory, count and minimum registers, encode/decode and result registers.
// ============================================================================
`default_nettype none

module mts_dp #(
    parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mts_pkg::cmd_t                     cmd,
    output mts_pkg::sts_t                     sts,
    input  logic [1:0]                        func,
    input  logic signed [mts_pkg::VAL_W-1:0]  push_value,
    output logic                              done,
    output logic signed [mts_pkg::VAL_W-1:0]  popped_value,
    output logic signed [mts_pkg::VAL_W-1:0]  current_minimum,
    output logic [1:0]                        status,
    output logic                              is_empty
);

    import mts_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [1:0]               func_reg;
    logic signed [VAL_W-1:0]  value_reg;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic signed [VAL_W-1:0]  min_reg;
    logic signed [VAL_W-1:0]  min_next;

    logic                     done_reg;
    logic signed [VAL_W-1:0]  popped_reg;
    logic signed [VAL_W-1:0]  popped_next;
    logic signed [VAL_W-1:0]  min_out_reg;
    logic [1:0]               status_reg;
    logic                     empty_reg;

    logic [CW-1:0]            top_index;
    logic [WORD_W-1:0]        rd_word;
    logic [WORD_W-1:0]        wr_word;
    logic signed [WORD_W-1:0] word_s;
    logic signed [WORD_W-1:0] value_s;
    logic signed [WORD_W-1:0] min_s;
    logic signed [WORD_W-1:0] enc_word;
    logic signed [WORD_W-1:0] restore_word;

    assign top_index = count_reg - CW'(1);

    mts_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.push_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (wr_word),
        .rd_en   (cmd.load),
        .rd_addr (top_index[AW-1:0]),
        .rd_data (rd_word)
    );

    assign sts.func  = func_reg;
    assign sts.empty = (count_reg == '0);
    assign sts.full  = (count_reg == CW'(STACK_DEPTH));

    always_comb
    begin
        value_s      = {{(WORD_W-VAL_W){value_reg[VAL_W-1]}}, value_reg};
        min_s        = {{(WORD_W-VAL_W){min_reg[VAL_W-1]}}, min_reg};
        word_s       = rd_word;
        enc_word     = (value_s <<< 1) - min_s;
        restore_word = (min_s <<< 1) - word_s;
        count_next   = count_reg;
        min_next     = min_reg;
        popped_next  = '0;
        wr_word      = value_s;

        if (cmd.push_en)
        begin
            count_next = count_reg + CW'(1);
            if (count_reg == '0)
            begin
                min_next = value_reg;
            end
            else if (value_reg < min_reg)
            begin
                // Below the minimum: store the encoded word, which also
                // carries the previous minimum.
                wr_word  = enc_word;
                min_next = value_reg;
            end
        end
        else if (cmd.pop_en)
        begin
            count_next = top_index;
            if (count_reg == CW'(1))
            begin
                popped_next = word_s[VAL_W-1:0];
                min_next    = '0;
            end
            else if (min_s < word_s)
            begin
                popped_next = word_s[VAL_W-1:0];
            end
            else
            begin
                popped_next = min_reg;
                min_next    = restore_word[VAL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            min_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            min_reg   <= min_next;
            done_reg  <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= func;
            value_reg <= push_value;
        end
        if (cmd.finish)
        begin
            popped_reg  <= popped_next;
            min_out_reg <= (count_next == '0) ? '0 : min_next;
            status_reg  <= cmd.status;
            empty_reg   <= (count_next == '0);
        end
    end

    assign done            = done_reg;
    assign popped_value    = popped_reg;
    assign current_minimum = min_out_reg;
    assign status          = status_reg;
    assign is_empty        = empty_reg;

endmodule

`default_nettype wire
